// ===== src/sconv_pkg.sv =====
// Shared types, constants and codes of the strided 2D convolution block.
`timescale 1ns / 1ps
package sconv_pkg;

    localparam int MAX_KERNEL_DEF = 5;
    localparam int MAX_COLS_DEF = 1024;
    localparam int DATA_BITS = 16;
    localparam int SUM_BITS = 40;
    localparam int IDX_BITS = 10;
    localparam int CFG_DATA_BITS = 11;
    localparam int MAX_ROWS = 1024;

    typedef logic signed [DATA_BITS-1:0] pix_t;
    typedef logic signed [2*DATA_BITS-1:0] prod_t;
    typedef logic signed [SUM_BITS-1:0] sum_t;

    localparam logic OP_COEFF = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    typedef enum logic [2:0] {
        CFG_IMAGE_ROWS  = 3'd0,
        CFG_IMAGE_COLS  = 3'd1,
        CFG_KERNEL_ROWS = 3'd2,
        CFG_KERNEL_COLS = 3'd3,
        CFG_STRIDE      = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic       opcode;
        logic [4:0] coeff_index;
        pix_t       value;
    } in_item_t;

    typedef struct packed {
        sum_t                sum;
        logic [IDX_BITS-1:0] out_row;
        logic [IDX_BITS-1:0] out_col;
        logic                last_of_frame;
    } out_item_t;

endpackage

// ===== src/sconv_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module sconv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AddrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [AddrBits-1:0] wr_addr,
    input  logic [WIDTH-1:0]    wr_data,
    input  logic                rd_en,
    input  logic [AddrBits-1:0] rd_addr,
    output logic [WIDTH-1:0]    rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// ===== src/sconv_cell.sv =====
// One window column cell: holds a pixel column, multiplies it and sums it.
`timescale 1ns / 1ps
module sconv_cell #(
    parameter int MAX_KERNEL = sconv_pkg::MAX_KERNEL_DEF
) (
    input  logic             aclk,
    input  logic             shift_en,
    input  logic             pipe_en,
    input  sconv_pkg::pix_t  col_in  [MAX_KERNEL],
    input  sconv_pkg::pix_t  coef    [MAX_KERNEL],
    output sconv_pkg::pix_t  col_out [MAX_KERNEL],
    output sconv_pkg::sum_t  sum_out
);
    import sconv_pkg::*;

    pix_t  col_reg  [MAX_KERNEL];
    prod_t prod_reg [MAX_KERNEL];
    sum_t  sum_reg;
    sum_t  sum_next;

    always_comb begin
        sum_next = '0;
        for (int a = 0; a < MAX_KERNEL; a++) begin
            sum_next = sum_next + sum_t'(prod_reg[a]);
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            col_reg <= col_in;
        end
        if (pipe_en) begin
            for (int a = 0; a < MAX_KERNEL; a++) begin
                // Positions outside the kernel carry a zero coefficient and may hold
                // pixels that were never loaded, so they contribute a clean zero.
                if (coef[a] == '0) begin
                    prod_reg[a] <= '0;
                end else begin
                    prod_reg[a] <= col_reg[a] * coef[a];
                end
            end
            sum_reg <= sum_next;
        end
    end

    assign col_out = col_reg;
    assign sum_out = sum_reg;
endmodule

// ===== src/strided_convolution_2d_top.sv =====
// Top level of the streaming strided valid 2D convolution block.
`timescale 1ns / 1ps
//  Channel   Ports                                     Direction  Carries
//  input     s_valid, s_ready, s_data                  in         coefficient or pixel item
//  result    m_valid, m_ready, m_data                  out        sum, row, column, frame end
//  config    cfg_valid, cfg_ready, cfg_addr, cfg_data  in         register writes
//
// One item is accepted per cycle while the result register is free or being taken.
// A pixel's result moves through these steps in order: the line store is read at the edge
// that accepts it, then come the window shift, the per-cell multiply, the per-cell
// column sum, and the final add into the result register. Reset is synchronous and
// active low; it clears the counters, the kernel and the pipeline valid flags. A stalled
// result holds the whole pipeline in place.
module strided_convolution_2d_top #(
    parameter int MAX_KERNEL = sconv_pkg::MAX_KERNEL_DEF,
    parameter int MAX_COLS   = sconv_pkg::MAX_COLS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  sconv_pkg::in_item_t                    s_data,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output sconv_pkg::out_item_t                   m_data,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [2:0]                             cfg_addr,
    input  logic [sconv_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import sconv_pkg::*;

    localparam int ColBits = $clog2(MAX_COLS) + 1;
    localparam int ColAddrBits = $clog2(MAX_COLS);
    localparam int KBits = $clog2(MAX_KERNEL + 1);
    localparam int BankBits = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int KIdxBits = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL * MAX_KERNEL) : 1;
    localparam int RowBits = 11;
    localparam int PhBits = 11;
    localparam int RcBits = $clog2(MAX_COLS);

    // Config registers keep raw bits (kernel sizes bits 2:0); sizes are clamped on use.
    logic [10:0] image_rows_reg, image_cols_reg, stride_reg;
    logic [2:0]  kernel_rows_reg, kernel_cols_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_rows_reg  <= 11'd32;
            image_cols_reg  <= 11'd32;
            kernel_rows_reg <= 3'd3;
            kernel_cols_reg <= 3'd3;
            stride_reg      <= 11'd1;
        end else if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_IMAGE_ROWS:  image_rows_reg  <= cfg_data;
                CFG_IMAGE_COLS:  image_cols_reg  <= cfg_data;
                CFG_KERNEL_ROWS: kernel_rows_reg <= cfg_data[2:0];
                CFG_KERNEL_COLS: kernel_cols_reg <= cfg_data[2:0];
                CFG_STRIDE:      stride_reg      <= cfg_data;
                default: ;
            endcase
        end
    end
    assign cfg_ready = 1'b1;

    // A size of zero acts as one; oversized values saturate.
    logic [RowBits-1:0] rows_c;
    logic [ColBits-1:0] cols_c;
    logic [KBits-1:0]   kr_c, kc_c;
    logic [10:0]        st_c;

    always_comb begin
        if (image_rows_reg == '0) rows_c = RowBits'(1);
        else if (32'(image_rows_reg) > MAX_ROWS) rows_c = RowBits'(MAX_ROWS);
        else rows_c = RowBits'(image_rows_reg);
        if (image_cols_reg == '0) cols_c = ColBits'(1);
        else if (32'(image_cols_reg) > MAX_COLS) cols_c = ColBits'(MAX_COLS);
        else cols_c = ColBits'(image_cols_reg);
        if (kernel_rows_reg == '0) kr_c = KBits'(1);
        else if (32'(kernel_rows_reg) > MAX_KERNEL) kr_c = KBits'(MAX_KERNEL);
        else kr_c = KBits'(kernel_rows_reg);
        if (kernel_cols_reg == '0) kc_c = KBits'(1);
        else if (32'(kernel_cols_reg) > MAX_KERNEL) kc_c = KBits'(MAX_KERNEL);
        else kc_c = KBits'(kernel_cols_reg);
        st_c = (stride_reg == '0) ? 11'd1 : stride_reg;
    end

    // The whole pipeline moves together whenever the result register can take a value.
    logic advance, accept, accept_pixel;
    assign advance = !m_valid || m_ready;
    assign s_ready = advance;
    assign accept = s_valid && advance;
    assign accept_pixel = accept && (s_data.opcode == OP_PIXEL);

    function automatic logic [BankBits-1:0] bank_inc(input logic [BankBits-1:0] b);
        return (32'(b) == MAX_KERNEL - 1) ? '0 : BankBits'(b + 1'b1);
    endfunction

    // Position and stride-grid tracking for the incoming pixel.
    logic [ColBits-1:0]  pixel_col_reg, pc, npc;
    logic [RowBits-1:0]  pixel_row_reg, pr, npr;
    logic [BankBits-1:0] bank_reg, bk, nbk;
    logic [PhBits-1:0]   row_phase_reg, col_phase_reg, rp, cp;
    logic [IDX_BITS-1:0] result_row_reg, rr;
    logic [RcBits-1:0]   result_col_reg, rc;
    logic                emit, last;

    always_comb begin
        pc = pixel_col_reg;
        pr = pixel_row_reg;
        bk = bank_reg;
        if (pc >= cols_c) begin
            pc = '0;
            pr = pr + 1'b1;
            bk = bank_inc(bk);
        end
        if (pr >= rows_c) begin
            pr = '0;
            bk = '0;
        end
        rp = row_phase_reg;
        rr = result_row_reg;
        cp = col_phase_reg;
        rc = result_col_reg;
        if (pc == '0 && 32'(pr) + 32'd1 >= 32'(kr_c)) begin
            if (32'(pr) + 32'd1 == 32'(kr_c)) begin
                rp = '0;
                rr = '0;
            end else if (32'(rp) + 32'd1 >= 32'(st_c)) begin
                rp = '0;
                rr = rr + 1'b1;
            end else begin
                rp = rp + 1'b1;
            end
        end
        if (32'(pc) + 32'd1 >= 32'(kc_c)) begin
            if (32'(pc) + 32'd1 == 32'(kc_c)) begin
                cp = '0;
                rc = '0;
            end else if (32'(cp) + 32'd1 >= 32'(st_c)) begin
                cp = '0;
                rc = rc + 1'b1;
            end else begin
                cp = cp + 1'b1;
            end
        end
        emit = (32'(pr) + 32'd1 >= 32'(kr_c)) && (32'(pc) + 32'd1 >= 32'(kc_c))
               && rp == '0 && cp == '0;
        // The frame's last result is the one whose next grid origin falls outside.
        last = (32'(pr) + 32'(st_c) >= 32'(rows_c)) && (32'(pc) + 32'(st_c) >= 32'(cols_c));
        npc = pc + 1'b1;
        npr = pr;
        nbk = bk;
        if (npc >= cols_c) begin
            npc = '0;
            npr = pr + 1'b1;
            nbk = bank_inc(bk);
            if (npr >= rows_c) begin
                npr = '0;
                nbk = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_col_reg  <= '0;
            pixel_row_reg  <= '0;
            bank_reg       <= '0;
            row_phase_reg  <= '0;
            col_phase_reg  <= '0;
            result_row_reg <= '0;
            result_col_reg <= '0;
        end else if (accept_pixel) begin
            pixel_col_reg  <= npc;
            pixel_row_reg  <= npr;
            bank_reg       <= nbk;
            row_phase_reg  <= rp;
            col_phase_reg  <= cp;
            result_row_reg <= rr;
            result_col_reg <= rc;
        end
    end

    // Line store: one bank per row modulo MAX_KERNEL, all read at the same column.
    logic [DATA_BITS-1:0] bank_dout [MAX_KERNEL];

    for (genvar q = 0; q < MAX_KERNEL; q++) begin : g_bank
        sconv_ram #(.WIDTH(DATA_BITS), .DEPTH(MAX_COLS)) u_ram (
            .aclk    (aclk),
            .wr_en   (accept_pixel && 32'(bk) == q),
            .wr_addr (pc[ColAddrBits-1:0]),
            .wr_data (s_data.value),
            .rd_en   (advance),
            .rd_addr (pc[ColAddrBits-1:0]),
            .rd_data (bank_dout[q])
        );
    end

    // Stage 1: the read column arrives from the line store.
    logic                s1_valid_reg, s1_op_reg, s1_emit_reg, s1_last_reg;
    logic [4:0]          s1_idx_reg;
    pix_t                s1_val_reg;
    logic [BankBits-1:0] s1_bank_reg;
    logic [IDX_BITS-1:0] s1_row_reg, s1_col_reg;
    logic                s2_valid_reg, s2_last_reg;
    logic [IDX_BITS-1:0] s2_row_reg, s2_col_reg;
    logic                s3_valid_reg, s3_last_reg;
    logic [IDX_BITS-1:0] s3_row_reg, s3_col_reg;
    logic                s4_valid_reg, s4_last_reg;
    logic [IDX_BITS-1:0] s4_row_reg, s4_col_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= s_valid;
            s2_valid_reg <= s1_valid_reg && s1_op_reg == OP_PIXEL && s1_emit_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_op_reg   <= s_data.opcode;
            s1_idx_reg  <= s_data.coeff_index;
            s1_val_reg  <= s_data.value;
            s1_emit_reg <= emit;
            s1_last_reg <= last;
            s1_bank_reg <= bk;
            s1_row_reg  <= rr;
            s1_col_reg  <= IDX_BITS'(rc);
            s2_row_reg  <= s1_row_reg;
            s2_col_reg  <= s1_col_reg;
            s2_last_reg <= s1_last_reg;
            s3_row_reg  <= s2_row_reg;
            s3_col_reg  <= s2_col_reg;
            s3_last_reg <= s2_last_reg;
            s4_row_reg  <= s3_row_reg;
            s4_col_reg  <= s3_col_reg;
            s4_last_reg <= s3_last_reg;
        end
    end

    // Kernel store, written in stream order so earlier pixels keep the old coefficients.
    pix_t kernel_reg [MAX_KERNEL*MAX_KERNEL];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < MAX_KERNEL * MAX_KERNEL; k++) begin
                kernel_reg[k] <= '0;
            end
        end else if (advance && s1_valid_reg && s1_op_reg == OP_COEFF
                     && 32'(s1_idx_reg) < MAX_KERNEL * MAX_KERNEL) begin
            kernel_reg[KIdxBits'(s1_idx_reg)] <= s1_val_reg;
        end
    end

    // Fresh column: entry a holds the pixel from a rows above the current one.
    pix_t fresh_col [MAX_KERNEL];

    always_comb begin
        int sel;
        fresh_col[0] = s1_val_reg;
        for (int a = 1; a < MAX_KERNEL; a++) begin
            sel = 32'(s1_bank_reg) + MAX_KERNEL - a;
            if (sel >= MAX_KERNEL) sel = sel - MAX_KERNEL;
            fresh_col[a] = pix_t'(bank_dout[sel]);
        end
    end

    // Cell k holds the column k places back; it pairs with kernel column kc-1-k.
    logic shift_en;
    assign shift_en = advance && s1_valid_reg && s1_op_reg == OP_PIXEL;

    pix_t cell_out [MAX_KERNEL][MAX_KERNEL];
    pix_t cell_coef [MAX_KERNEL][MAX_KERNEL];
    sum_t cell_sum [MAX_KERNEL];

    for (genvar k = 0; k < MAX_KERNEL; k++) begin : g_cell
        always_comb begin
            int idx;
            for (int a = 0; a < MAX_KERNEL; a++) begin
                idx = (32'(kr_c) - 1 - a) * MAX_KERNEL + (32'(kc_c) - 1 - k);
                if (k < 32'(kc_c) && a < 32'(kr_c)) begin
                    cell_coef[k][a] = kernel_reg[KIdxBits'(idx)];
                end else begin
                    cell_coef[k][a] = '0;
                end
            end
        end

        if (k == 0) begin : g_head
            sconv_cell #(.MAX_KERNEL(MAX_KERNEL)) u_cell (
                .aclk     (aclk),
                .shift_en (shift_en),
                .pipe_en  (advance),
                .col_in   (fresh_col),
                .coef     (cell_coef[k]),
                .col_out  (cell_out[k]),
                .sum_out  (cell_sum[k])
            );
        end else begin : g_body
            sconv_cell #(.MAX_KERNEL(MAX_KERNEL)) u_cell (
                .aclk     (aclk),
                .shift_en (shift_en),
                .pipe_en  (advance),
                .col_in   (cell_out[k-1]),
                .coef     (cell_coef[k]),
                .col_out  (cell_out[k]),
                .sum_out  (cell_sum[k])
            );
        end
    end

    // Final add of the column sums into the result register.
    sum_t      total;
    out_item_t m_data_reg;
    logic      m_valid_reg;

    always_comb begin
        total = '0;
        for (int k = 0; k < MAX_KERNEL; k++) begin
            total = total + cell_sum[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && s4_valid_reg) begin
            m_data_reg.sum           <= total;
            m_data_reg.out_row       <= s4_row_reg;
            m_data_reg.out_col       <= s4_col_reg;
            m_data_reg.last_of_frame <= s4_last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
endmodule
